// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PFVU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must follow.
`define PFVU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/pfvu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_pkg
// Types and constants for the particle velocity update pipeline.
// ----------------------------------------------------------------------------
package pfvu_pkg;

    localparam int COMP_W       = 21;
    localparam int FRONT_STAGES = 6;
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 31;
    // front end, root, divide, force multiply, output register
    localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + 2;

    localparam logic [63:0] ATTR_MIN_SQ   = 64'd4295;
    localparam logic [62:0] GRAVITY_RESET = 63'd4392784756736;

    typedef enum logic [2:0] {
        REG_GRAVITY  = 3'd0,
        REG_WIND     = 3'd1,
        REG_FIELD    = 3'd2,
        REG_BOX_MIN  = 3'd3,
        REG_BOX_MAX  = 3'd4,
        REG_ATTRACT  = 3'd5,
        REG_CONTROL  = 3'd6,
        REG_STRENGTH = 3'd7
    } pfvu_reg_t;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][36:0] gsp;
        logic [2:0][37:0] wp;
        logic [2:0][37:0] fp;
        logic [31:0]      dragdt;
        logic [30:0]      pull;
        logic [15:0]      dt;
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             en;
        logic             drag_on;
        logic             box_hit;
        logic             att_on;
    } pfvu_s1_t;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][53:0] gfull;
        logic [2:0][29:0] wr;
        logic [2:0][29:0] fr;
        logic [31:0]      factor;
        logic [2:0][61:0] sq;
        logic [30:0]      pull;
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             en;
        logic             drag_on;
        logic             box_hit;
        logic             att_on;
    } pfvu_s2_t;

    // what the attractor path needs downstream of the front end
    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic [30:0]      pull;
        logic             att_ok;
    } pfvu_carry_t;

    typedef struct packed {
        pfvu_carry_t      c;
        logic [63:0]      sum;
        logic [2:0][29:0] fr;
        logic [31:0]      factor;
        logic             drag_on;
        logic             box_hit;
    } pfvu_mid_t;

    typedef struct packed {
        pfvu_mid_t        m;
        logic [2:0][63:0] vprod;
    } pfvu_s4_t;

    typedef struct packed {
        pfvu_carry_t c;
        logic [63:0] n;
        logic [33:0] rem;
        logic [31:0] root;
    } pfvu_sqrt_t;

    typedef struct packed {
        pfvu_carry_t      c;
        logic [31:0]      r;
        logic [2:0][31:0] rem;
        logic [2:0][30:0] q;
    } pfvu_div_t;

    typedef struct packed {
        logic [2:0][31:0] vel;
        logic [2:0][62:0] prod;
        logic             att_ok;
    } pfvu_fm_t;

    function automatic logic signed [20:0] vec_comp(input logic [62:0] vec, input int idx);
        return vec[COMP_W*idx +: COMP_W];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
        logic signed [31:0] y;
        if (x > 41'sh0_7FFF_FFFF)
            y = 32'sh7FFF_FFFF;
        else if (x < -41'sh0_8000_0000)
            y = 32'sh8000_0000;
        else
            y = x[31:0];
        return y;
    endfunction

endpackage

// ----- src/particle_force_velocity_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_velocity_update
// Fixed-point velocity update: gravity, wind, drag, box field, attractor.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the particle fields and pulse start; a transfer happens at
//   each edge with start high and busy low. busy stays low, so one particle
//   can enter every cycle.
//   Output: done is high for one cycle with new_vel_x/y/z; that cycle is the
//   transfer. There is no back pressure on the result side.
//   Pipeline: throughput one particle per cycle, through 6 front stages
//   (products, rounding, drag, box), a 32-stage square root, a 31-stage
//   divider (one quotient bit per stage, three lanes) and two output stages.
//   Config: APB, 64-bit data, register i at byte address 8*i; write only
//   while no particle is in flight. Reads are zero-wait.
//   Reset: clears all pipeline valid bits and loads register defaults
//   (gravity y = -9.8, enable on, everything else off).
// ----------------------------------------------------------------------------
module particle_force_velocity_update
    import pfvu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [15:0]        delta_time,
    input  logic signed [15:0] gravity_scale,
    output logic               done,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z
);

    // ---------------- configuration ----------------
    logic [62:0] gravity_reg, wind_reg, field_reg, box_min_reg, box_max_reg, attract_reg;
    logic [17:0] control_reg;
    logic [14:0] strength_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg  <= GRAVITY_RESET;
            wind_reg     <= '0;
            field_reg    <= '0;
            box_min_reg  <= '0;
            box_max_reg  <= '0;
            attract_reg  <= '0;
            control_reg  <= 18'd1;
            strength_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (pfvu_reg_t'(paddr[5:3]))
                REG_GRAVITY:  gravity_reg  <= pwdata[62:0];
                REG_WIND:     wind_reg     <= pwdata[62:0];
                REG_FIELD:    field_reg    <= pwdata[62:0];
                REG_BOX_MIN:  box_min_reg  <= pwdata[62:0];
                REG_BOX_MAX:  box_max_reg  <= pwdata[62:0];
                REG_ATTRACT:  attract_reg  <= pwdata[62:0];
                REG_CONTROL:  control_reg  <= pwdata[17:0];
                REG_STRENGTH: strength_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (pfvu_reg_t'(paddr[5:3]))
            REG_GRAVITY:  prdata = {1'b0, gravity_reg};
            REG_WIND:     prdata = {1'b0, wind_reg};
            REG_FIELD:    prdata = {1'b0, field_reg};
            REG_BOX_MIN:  prdata = {1'b0, box_min_reg};
            REG_BOX_MAX:  prdata = {1'b0, box_max_reg};
            REG_ATTRACT:  prdata = {1'b0, attract_reg};
            REG_CONTROL:  prdata = {46'd0, control_reg};
            REG_STRENGTH: prdata = {49'd0, strength_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- stage 1: first products, box test, offsets ----------------
    logic signed [31:0] vin [3];
    logic signed [31:0] pin [3];
    pfvu_s1_t s1_next, s1_reg;
    logic     s1_vld_reg;

    assign vin[0] = vel_x;
    assign vin[1] = vel_y;
    assign vin[2] = vel_z;
    assign pin[0] = pos_x;
    assign pin[1] = pos_y;
    assign pin[2] = pos_z;

    always_comb
    begin
        logic signed [20:0] gc, wc, fc, mn, mx, ap;
        logic signed [36:0] gx;
        logic signed [37:0] wx, fx;
        logic signed [31:0] lo, hi;
        logic signed [32:0] d;
        logic signed [16:0] dts;
        logic [2:0][32:0]   mag_w;
        logic               in_box, big;
        s1_next = '0;
        dts     = {1'b0, delta_time};
        in_box  = 1'b1;
        mag_w   = '0;
        for (int i = 0; i < 3; i++)
        begin
            gc = vec_comp(gravity_reg, i);
            wc = vec_comp(wind_reg, i);
            fc = vec_comp(field_reg, i);
            mn = vec_comp(box_min_reg, i);
            mx = vec_comp(box_max_reg, i);
            ap = vec_comp(attract_reg, i);
            gx = gc * gravity_scale;
            wx = wc * dts;
            fx = fc * dts;
            s1_next.vel[i] = vin[i];
            s1_next.gsp[i] = gx;
            s1_next.wp[i]  = wx;
            s1_next.fp[i]  = fx;
            lo = {{3{mn[20]}}, mn, 8'h00};
            hi = {{3{mx[20]}}, mx, 8'h00};
            if (pin[i] < lo || pin[i] > hi)
                in_box = 1'b0;
            d = {{4{ap[20]}}, ap, 8'h00} - {pin[i][31], pin[i]};
            s1_next.neg[i] = d[32];
            mag_w[i] = d[32] ? -d : d;
        end
        // offsets stay below 2^32, so one halving always brings them under 2^31
        big = (|mag_w[0][32:31]) | (|mag_w[1][32:31]) | (|mag_w[2][32:31]);
        for (int i = 0; i < 3; i++)
            s1_next.mag[i] = big ? mag_w[i][31:1] : mag_w[i][30:0];
        s1_next.dragdt  = control_reg[17:2] * delta_time;
        s1_next.pull    = strength_reg * delta_time;
        s1_next.dt      = delta_time;
        s1_next.en      = control_reg[0];
        s1_next.drag_on = control_reg[0] & (|control_reg[17:2]);
        s1_next.box_hit = control_reg[0] & control_reg[1] & in_box;
        s1_next.att_on  = |strength_reg;
    end

    // ---------------- stage 2: gravity*dt, squares, drag factor ----------------
    pfvu_s2_t s2_next, s2_reg;
    logic     s2_vld_reg;

    always_comb
    begin
        logic signed [53:0] gf;
        logic signed [37:0] wt, ft;
        logic signed [32:0] fac;
        logic signed [16:0] dts;
        s2_next = '0;
        dts     = {1'b0, s1_reg.dt};
        for (int i = 0; i < 3; i++)
        begin
            gf = $signed(s1_reg.gsp[i]) * dts;
            wt = $signed(s1_reg.wp[i]) + 38'sd128;
            ft = $signed(s1_reg.fp[i]) + 38'sd128;
            s2_next.gfull[i] = gf;
            s2_next.wr[i]    = wt[37:8];
            s2_next.fr[i]    = ft[37:8];
            s2_next.sq[i]    = s1_reg.mag[i] * s1_reg.mag[i];
        end
        fac = 33'sh0_8000_0000 - $signed({1'b0, s1_reg.dragdt});
        s2_next.factor  = fac[32] ? 32'd0 : fac[31:0];
        s2_next.vel     = s1_reg.vel;
        s2_next.pull    = s1_reg.pull;
        s2_next.mag     = s1_reg.mag;
        s2_next.neg     = s1_reg.neg;
        s2_next.en      = s1_reg.en;
        s2_next.drag_on = s1_reg.drag_on;
        s2_next.box_hit = s1_reg.box_hit;
        s2_next.att_on  = s1_reg.att_on;
    end

    // ---------------- stage 3: add gravity and wind, distance squared ----------------
    pfvu_mid_t s3_next, s3_reg;
    logic      s3_vld_reg;

    always_comb
    begin
        logic signed [53:0] gt;
        logic signed [37:0] gr;
        logic signed [31:0] vs;
        logic signed [29:0] ws;
        logic signed [40:0] tot;
        s3_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            gt  = $signed(s2_reg.gfull[i]) + 54'sd32768;
            gr  = gt[53:16];
            vs  = s2_reg.vel[i];
            ws  = s2_reg.wr[i];
            tot = vs + gr + ws;
            s3_next.c.vel[i] = s2_reg.en ? sat32(tot) : vs;
        end
        s3_next.sum      = {2'b00, s2_reg.sq[0]} + {2'b00, s2_reg.sq[1]} + {2'b00, s2_reg.sq[2]};
        s3_next.c.att_ok = s2_reg.en & s2_reg.att_on & (s3_next.sum >= ATTR_MIN_SQ);
        s3_next.c.mag    = s2_reg.mag;
        s3_next.c.neg    = s2_reg.neg;
        s3_next.c.pull   = s2_reg.pull;
        s3_next.fr       = s2_reg.fr;
        s3_next.factor   = s2_reg.factor;
        s3_next.drag_on  = s2_reg.drag_on;
        s3_next.box_hit  = s2_reg.box_hit;
    end

    // ---------------- stage 4: drag product ----------------
    pfvu_s4_t s4_next, s4_reg;
    logic     s4_vld_reg;

    always_comb
    begin
        logic signed [63:0] vp;
        logic signed [31:0] vs;
        logic signed [32:0] fs;
        s4_next   = '0;
        s4_next.m = s3_reg;
        fs        = {1'b0, s3_reg.factor};
        for (int i = 0; i < 3; i++)
        begin
            vs = s3_reg.c.vel[i];
            vp = vs * fs;
            s4_next.vprod[i] = vp;
        end
    end

    // ---------------- stage 5: drag rounding ----------------
    pfvu_mid_t s5_next, s5_reg;
    logic      s5_vld_reg;

    always_comb
    begin
        logic signed [63:0] t;
        logic signed [32:0] r33;
        logic signed [40:0] x;
        s5_next = s4_reg.m;
        for (int i = 0; i < 3; i++)
        begin
            t   = $signed(s4_reg.vprod[i]) + 64'sd1073741824;
            r33 = t[63:31];
            x   = r33;
            if (s4_reg.m.drag_on)
                s5_next.c.vel[i] = sat32(x);
        end
    end

    // ---------------- stage 6: box field ----------------
    pfvu_sqrt_t s6_next, s6_reg;
    logic       s6_vld_reg;

    always_comb
    begin
        logic signed [31:0] vs;
        logic signed [29:0] fs;
        logic signed [40:0] tot;
        s6_next.c    = s5_reg.c;
        s6_next.n    = s5_reg.sum;
        s6_next.rem  = '0;
        s6_next.root = '0;
        for (int i = 0; i < 3; i++)
        begin
            vs  = s5_reg.c.vel[i];
            fs  = s5_reg.fr[i];
            tot = vs + fs;
            if (s5_reg.box_hit)
                s6_next.c.vel[i] = sat32(tot);
        end
    end

    // ---------------- square root, two radicand bits per stage ----------------
    pfvu_sqrt_t sq_next [SQRT_STAGES];
    pfvu_sqrt_t sq_reg  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] sq_vld_reg;

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        pfvu_sqrt_t src;
        logic       src_vld;

        if (k == 0)
        begin : g_first
            assign src     = s6_reg;
            assign src_vld = s6_vld_reg;
        end
        else
        begin : g_rest
            assign src     = sq_reg[k-1];
            assign src_vld = sq_vld_reg[k-1];
        end

        always_comb
        begin
            logic [35:0] rsh, trial, diff;
            rsh   = {src.rem, src.n[63:62]};
            trial = {2'b00, src.root, 2'b01};
            diff  = rsh - trial;
            sq_next[k].c = src.c;
            sq_next[k].n = {src.n[61:0], 2'b00};
            if (rsh >= trial)
            begin
                sq_next[k].rem  = diff[33:0];
                sq_next[k].root = {src.root[30:0], 1'b1};
            end
            else
            begin
                sq_next[k].rem  = rsh[33:0];
                sq_next[k].root = {src.root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            sq_reg[k] <= sq_next[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k] <= 1'b0;
            else
                sq_vld_reg[k] <= src_vld;
        end
    end

    // ---------------- unit vector: (mag << 30) / root, one bit per stage ----------------
    pfvu_div_t dv_next [DIV_STAGES];
    pfvu_div_t dv_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] dv_vld_reg;

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        pfvu_div_t  src;
        logic       src_vld;
        logic [2:0] nb;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                src.c = sq_reg[SQRT_STAGES-1].c;
                src.r = sq_reg[SQRT_STAGES-1].root;
                src.q = '0;
                for (int i = 0; i < 3; i++)
                begin
                    src.rem[i] = {2'b00, sq_reg[SQRT_STAGES-1].c.mag[i][30:1]};
                    nb[i]      = sq_reg[SQRT_STAGES-1].c.mag[i][0];
                end
            end
            assign src_vld = sq_vld_reg[SQRT_STAGES-1];
        end
        else
        begin : g_rest
            assign src     = dv_reg[k-1];
            assign src_vld = dv_vld_reg[k-1];
            assign nb      = 3'b000;
        end

        always_comb
        begin
            logic [32:0] rsh, diff;
            dv_next[k].c = src.c;
            dv_next[k].r = src.r;
            for (int i = 0; i < 3; i++)
            begin
                rsh  = {src.rem[i], nb[i]};
                diff = rsh - {1'b0, src.r};
                if (rsh >= {1'b0, src.r})
                begin
                    dv_next[k].rem[i] = diff[31:0];
                    dv_next[k].q[i]   = {src.q[i][29:0], 1'b1};
                end
                else
                begin
                    dv_next[k].rem[i] = rsh[31:0];
                    dv_next[k].q[i]   = {src.q[i][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k] <= dv_next[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k] <= 1'b0;
            else
                dv_vld_reg[k] <= src_vld;
        end
    end

    // ---------------- force multiply ----------------
    pfvu_fm_t fm_next, fm_reg;
    logic     fm_vld_reg;

    always_comb
    begin
        logic signed [31:0] u, fs;
        logic signed [62:0] p;
        fs             = {1'b0, dv_reg[DIV_STAGES-1].c.pull};
        fm_next.vel    = dv_reg[DIV_STAGES-1].c.vel;
        fm_next.att_ok = dv_reg[DIV_STAGES-1].c.att_ok;
        for (int i = 0; i < 3; i++)
        begin
            u = {1'b0, dv_reg[DIV_STAGES-1].q[i]};
            if (dv_reg[DIV_STAGES-1].c.neg[i])
                u = -u;
            p = u * fs;
            fm_next.prod[i] = p;
        end
    end

    // ---------------- output: attractor add ----------------
    logic [2:0][31:0] out_next, out_reg;
    logic             done_reg;

    always_comb
    begin
        logic signed [62:0] t;
        logic signed [24:0] a;
        logic signed [31:0] vs;
        logic signed [40:0] tot;
        for (int i = 0; i < 3; i++)
        begin
            t   = $signed(fm_reg.prod[i]) + 63'sd137438953472;
            a   = t[62:38];
            vs  = fm_reg.vel[i];
            tot = vs + a;
            out_next[i] = fm_reg.att_ok ? sat32(tot) : vs;
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        s5_reg  <= s5_next;
        s6_reg  <= s6_next;
        fm_reg  <= fm_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            fm_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start & ~busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            fm_vld_reg <= dv_vld_reg[DIV_STAGES-1];
            done_reg   <= fm_vld_reg;
        end
    end

    assign done      = done_reg;
    assign new_vel_x = out_reg[0];
    assign new_vel_y = out_reg[1];
    assign new_vel_z = out_reg[2];

endmodule

// ----- src/pfvu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfvu_checker
// Port-level timing checks for the particle velocity update block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfvu_checker
    import pfvu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    `PFVU_ASSERT(a_never_busy, !busy, "busy asserted on a fully pipelined block")
    `PFVU_ASSERT(a_pready_high, pready, "pready dropped")
    `PFVU_ASSERT_IMP(a_fixed_latency, start && !busy, ##LATENCY done, "result missing")
    `PFVU_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, LATENCY), "unexpected result")

endmodule

bind particle_force_velocity_update pfvu_checker u_pfvu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);

// ----- tb/particle_force_velocity_update_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_force_velocity_update_tb
// Self-checking bench for the fixed-point particle velocity update.
// A directed table walked under three register settings is followed by
// randomized settings and particles. The result stream is compared against
// a bit-accurate behavioral predictor, in order, one transfer per particle.
// ----------------------------------------------------------------------------
module particle_force_velocity_update_tb
    import pfvu_pkg::*;
();

    localparam int STALL_LIMIT = 5000;
    localparam int N_PHASES    = 14;
    localparam int PER_PHASE   = 38;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]        dt;
        logic signed [15:0] gs;
        logic               unchanged;  // dt = 0: velocity must pass through
    } particle_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [5:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [15:0]        delta_time = '0;
    logic signed [15:0] gravity_scale = '0;
    logic               done;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;

    logic [62:0] reg_shadow [8];
    vel_t        vel_expect_q [$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int          stall_cnt = 0;
    bit          gaps_on = 1'b1;

    particle_force_velocity_update dut (.*);

    always #1 clk = ~clk;

    function automatic longint vcomp(input logic [62:0] v, input int i);
        logic signed [20:0] c;
        c = v[21*i +: 21];
        return c;
    endfunction

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint round_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic vel_t update_velocity(input particle_t p);
        longint v[3], ps[3];
        longint dt, gs, drag, f, pull, d, u;
        longint unsigned mag[3], s, mx, r;
        bit neg[3];
        bit hit;
        logic [62:0] ctl;
        vel_t o;
        v[0] = longint'(p.vx);
        v[1] = longint'(p.vy);
        v[2] = longint'(p.vz);
        ps[0] = longint'(p.px);
        ps[1] = longint'(p.py);
        ps[2] = longint'(p.pz);
        dt = longint'(p.dt);
        gs = longint'(p.gs);
        ctl = reg_shadow[REG_CONTROL];
        if (ctl[0])
        begin
            drag = longint'(ctl[17:2]);
            for (int i = 0; i < 3; i++)
                v[i] = clamp32(v[i]
                    + round_shift(vcomp(reg_shadow[REG_GRAVITY], i) * gs * dt, 16)
                    + round_shift(vcomp(reg_shadow[REG_WIND], i) * dt, 8));
            if (drag > 0)
            begin
                f = (64'sd1 <<< 31) - drag * dt;
                if (f < 0)
                    f = 0;
                for (int i = 0; i < 3; i++)
                    v[i] = clamp32(round_shift(v[i] * f, 31));
            end
            if (ctl[1])
            begin
                hit = 1'b1;
                for (int i = 0; i < 3; i++)
                    if (ps[i] < vcomp(reg_shadow[REG_BOX_MIN], i) * 256 ||
                        ps[i] > vcomp(reg_shadow[REG_BOX_MAX], i) * 256)
                        hit = 1'b0;
                if (hit)
                    for (int i = 0; i < 3; i++)
                        v[i] = clamp32(v[i]
                            + round_shift(vcomp(reg_shadow[REG_FIELD], i) * dt, 8));
            end
            if (reg_shadow[REG_STRENGTH] != 0)
            begin
                pull = longint'(reg_shadow[REG_STRENGTH]) * dt;
                mx = 0;
                s = 0;
                for (int i = 0; i < 3; i++)
                begin
                    d = vcomp(reg_shadow[REG_ATTRACT], i) * 256 - ps[i];
                    neg[i] = d < 0;
                    mag[i] = neg[i] ? -d : d;
                    if (mag[i] > mx)
                        mx = mag[i];
                end
                // scale down until every axis fits in 31 bits
                while (mx >= (64'd1 << 31))
                begin
                    mx >>= 1;
                    for (int i = 0; i < 3; i++)
                        mag[i] >>= 1;
                end
                for (int i = 0; i < 3; i++)
                    s += mag[i] * mag[i];
                if (s >= 64'd4295)
                begin
                    r = int_sqrt(s);
                    for (int i = 0; i < 3; i++)
                    begin
                        u = (mag[i] << 30) / r;
                        if (neg[i])
                            u = -u;
                        v[i] = clamp32(v[i] + round_shift(u * pull, 38));
                    end
                end
            end
        end
        o.x = 32'(v[0]);
        o.y = 32'(v[1]);
        o.z = 32'(v[2]);
        return o;
    endfunction

    task automatic write_reg(input pfvu_reg_t idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CONTROL:  reg_shadow[idx] = {45'd0, val[17:0]};
            REG_STRENGTH: reg_shadow[idx] = {48'd0, val[14:0]};
            default:      reg_shadow[idx] = val[62:0];
        endcase
    endtask

    // every particle yields exactly one result, so an empty queue means idle
    task automatic wait_drained();
        while (vel_expect_q.size() != 0)
            @(posedge clk);
        n_settings++;
    endtask

    task automatic send_particle(input particle_t p);
        while (gaps_on && $urandom_range(99) < 34)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        vel_x         <= p.vx;
        vel_y         <= p.vy;
        vel_z         <= p.vz;
        pos_x         <= p.px;
        pos_y         <= p.py;
        pos_z         <= p.pz;
        delta_time    <= p.dt;
        gravity_scale <= p.gs;
        do
            @(posedge clk);
        while (busy);
        if (p.unchanged)
            vel_expect_q.push_back('{p.vx, p.vy, p.vz});
        else
            vel_expect_q.push_back(update_velocity(p));
        n_sent++;
    endtask

    function automatic logic [62:0] rand_vec(input bit narrow);
        logic [62:0] v;
        for (int i = 0; i < 3; i++)
            v[21*i +: 21] = narrow ? 21'($urandom_range(0, 8191) - 4096) : 21'($urandom);
        return v;
    endfunction

    function automatic logic [31:0] rand_word(input int kind);
        case (kind)
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return $urandom_range(0, 2000000) - 1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        longint lo, hi, c[3];
        int kind;
        p.vx = rand_word($urandom_range(0, 9));
        p.vy = rand_word($urandom_range(0, 9));
        p.vz = rand_word($urandom_range(0, 9));
        kind = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++)
        begin
            if (kind == 1)
            begin
                lo = vcomp(reg_shadow[REG_BOX_MIN], i) * 256;
                hi = vcomp(reg_shadow[REG_BOX_MAX], i) * 256;
                c[i] = (lo <= hi) ? lo + longint'({$urandom, $urandom} % (hi - lo + 1)) : lo;
            end
            else if (kind == 2)
            begin
                c[i] = vcomp(reg_shadow[REG_ATTRACT], i) * 256 + $urandom_range(0, 80) - 40;
            end
            else
            begin
                c[i] = longint'(signed'(rand_word($urandom_range(0, 9))));
            end
        end
        p.px = 32'(c[0]);
        p.py = 32'(c[1]);
        p.pz = 32'(c[2]);
        case ($urandom_range(0, 7))
            0:       p.dt = 16'h0000;
            1:       p.dt = 16'hFFFF;
            default: p.dt = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       p.gs = 16'sh7FFF;
            1:       p.gs = -16'sh8000;
            2:       p.gs = 16'sh0100;
            default: p.gs = 16'($urandom);
        endcase
        p.unchanged = 1'b0;
        return p;
    endfunction

    // results are valid for exactly one cycle; compare against the oldest entry
    always @(posedge clk)
    begin
        vel_t want;
        if (rst_n && done)
        begin
            if (vel_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d",
                         $time, new_vel_x, new_vel_y, new_vel_z);
                n_errors++;
            end
            else
            begin
                want = vel_expect_q.pop_front();
                n_checked++;
                if (new_vel_x !== want.x)
                begin
                    $display("%0t: new_vel_x expected %0d got %0d", $time, want.x, new_vel_x);
                    n_errors++;
                end
                if (new_vel_y !== want.y)
                begin
                    $display("%0t: new_vel_y expected %0d got %0d", $time, want.y, new_vel_y);
                    n_errors++;
                end
                if (new_vel_z !== want.z)
                begin
                    $display("%0t: new_vel_z expected %0d got %0d", $time, want.z, new_vel_z);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt > STALL_LIMIT)
            begin
                $display("FAIL particle_force_velocity_update");
                $finish;
            end
        end
    end

    initial
    begin
        particle_t dir_tab [8];
        particle_t p;
        logic [63:0] ctl;

        reg_shadow[REG_GRAVITY]  = GRAVITY_RESET;
        reg_shadow[REG_WIND]     = '0;
        reg_shadow[REG_FIELD]    = '0;
        reg_shadow[REG_BOX_MIN]  = '0;
        reg_shadow[REG_BOX_MAX]  = '0;
        reg_shadow[REG_ATTRACT]  = '0;
        reg_shadow[REG_CONTROL]  = 63'd1;
        reg_shadow[REG_STRENGTH] = '0;

        //          vx             vy             vz            px        py
        //          pz        dt        gs           unchanged
        dir_tab = '{
            '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0, 32'sh0, 32'sh0,
              32'sh0, 16'h0000, 16'sh7FFF, 1'b1},
            '{-32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1, 32'sh7FFF_FFFF, -32'sh8000_0000,
              32'sh1234_5678, 16'h0000, -16'sh8000, 1'b1},
            '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
              32'sh0, 16'hFFFF, 16'sh0100, 1'b0},
            '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0001_0000, 32'sh0,
              -32'sh0001_0000, 16'hFFFF, 16'sh7FFF, 1'b0},
            '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
              32'sh7FFF_FFFF, -32'sh8000_0000, 16'hFFFF, -16'sh8000, 1'b0},
            '{32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000, 32'sh0000_0010,
              32'sh0000_0010, 32'sh0000_0010, 16'h0001, 16'sh0001, 1'b0},
            '{32'sh0, 32'sh0, 32'sh0, 32'sh0064_0000, -32'sh0064_0000,
              32'sh0, 16'h8000, 16'shFF00, 1'b0},
            '{32'sh5555_5555, -32'sh2AAA_AAAB, 32'sh0F0F_0F0F, 32'sh0000_0020,
              32'sh0000_0020, 32'sh0000_0021, 16'h1111, 16'sh0180, 1'b0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, then disabled, then drag / inverted box / attractor at origin
        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                write_reg(REG_CONTROL, 64'h0);
            end
            else if (ph == 2)
            begin
                write_reg(REG_BOX_MIN, 64'h0000_0000_0020_0010);
                write_reg(REG_BOX_MAX, 64'h0000_0000_0000_0000);
                write_reg(REG_ATTRACT, 64'h0);
                write_reg(REG_STRENGTH, 64'h7FFF);
                write_reg(REG_CONTROL, 64'h3_FFFF);
            end
            foreach (dir_tab[i])
                send_particle(dir_tab[i]);
            start <= 1'b0;
            wait_drained();
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                for (int r = 0; r < 8; r++)
                    write_reg(pfvu_reg_t'(r), 64'hFFFF_FFFF_FFFF_FFFF);
            end
            else if (ph == 1)
            begin
                for (int r = 0; r < 8; r++)
                    write_reg(pfvu_reg_t'(r), (r == REG_CONTROL) ? 64'h1 : 64'h0);
            end
            else
            begin
                write_reg(REG_GRAVITY, {1'($urandom_range(0, 1)),
                                        rand_vec(1'($urandom_range(0, 1)))});
                write_reg(REG_WIND, {1'b0, rand_vec($urandom_range(0, 3) != 0)});
                write_reg(REG_FIELD, {1'b0, rand_vec($urandom_range(0, 3) != 0)});
                write_reg(REG_BOX_MIN, {1'b0, rand_vec(1'b1)});
                write_reg(REG_BOX_MAX, {1'b0, rand_vec(1'b1)});
                write_reg(REG_ATTRACT, {1'b0, rand_vec($urandom_range(0, 3) != 0)});
                ctl = {1'($urandom_range(0, 1)), 45'h0, 16'($urandom), 1'($urandom),
                       1'($urandom_range(0, 5) != 0)};
                if ($urandom_range(0, 2) == 0)
                    ctl[17:2] = 16'h0;
                write_reg(REG_CONTROL, ctl);
                write_reg(REG_STRENGTH, ($urandom_range(0, 3) == 0) ? 64'h0 : 64'($urandom));
            end
            gaps_on = (ph != 5);
            repeat (PER_PHASE)
            begin
                p = rand_particle();
                send_particle(p);
            end
            start <= 1'b0;
            wait_drained();
        end

        repeat (LATENCY + 10) @(posedge clk);
        $display("Covered %0d particles over %0d register settings; %0d results compared.",
                 n_sent, n_settings, n_checked);
        if (n_errors == 0 && vel_expect_q.size() == 0)
            $display("PASS particle_force_velocity_update");
        else
            $display("FAIL particle_force_velocity_update");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/pfvu_pkg.sv
src/particle_force_velocity_update.sv
src/pfvu_checker.sv
tb/particle_force_velocity_update_tb.sv
